// File: hdl/ghd_pkg.sv
// Package for the grid heat diffusion block: word types, register codes,
// reset values and datapath widths. No dependencies.
package ghd_pkg;

  localparam int unsigned HEAT_W  = 16;  // heat value width
  localparam int unsigned POS_W   = 3;   // row and column field width
  localparam int unsigned SHIFT_W = 4;   // shift register width
  localparam int unsigned CFG_W   = 16;  // widest configuration register
  localparam int unsigned CIDX_W  = 2;   // configuration index width
  localparam int unsigned ARITH_W = 22;  // signed width of the cell update math

  localparam logic [HEAT_W-1:0]  PEAK_RST  = 16'd32767;
  localparam logic [HEAT_W-1:0]  HOLD_RST  = 16'd30000;
  localparam logic [SHIFT_W-1:0] DIFF_RST  = 4'd5;
  localparam logic [SHIFT_W-1:0] DECAY_RST = 4'd3;

  typedef enum logic [CIDX_W-1:0] {
    REG_PEAK  = 2'd0,
    REG_HOLD  = 2'd1,
    REG_DIFF  = 2'd2,
    REG_DECAY = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    REQ_KEY  = 1'b0,
    REQ_TICK = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic             req_type;
    logic [POS_W-1:0] key_row;
    logic [POS_W-1:0] key_col;
    logic             key_down;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0]  cell_row;
    logic [POS_W-1:0]  cell_col;
    logic [HEAT_W-1:0] intensity;
    logic              last_cell;
  } out_word_t;

endpackage

// File: hdl/grid_heat_diffusion.sv
// Grid heat diffusion top level: heat grid memory, tick sequencer and the
// staged cell update datapath. Depends on ghd_pkg.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+-----------------------------
//   input   | in        | in_valid_i / in_stall_o | in_word_t (event or tick)
//   output  | out       | out_valid_o/out_stall_i | out_word_t (one cell)
//   config  | in        | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// A key event does not stall the input. While the output is not stalled, the
// memory read port delivers one cell per cycle during a frame tick, and the
// first result needs a lead of one row. An output stall freezes the whole
// tick pipeline.
// Reset clears the grid at once through one valid bit per cell; no clearing
// pass runs, and the block takes a word in the first cycle after reset.

module grid_heat_diffusion
  import ghd_pkg::*;
#(
  parameter int unsigned ROWS = 4,
  parameter int unsigned COLS = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_word_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned CELLS  = ROWS * COLS;
  localparam int unsigned IDX_W  = $clog2(CELLS);
  localparam int unsigned DEPTH  = 2 ** (IDX_W + 1);
  localparam int unsigned J_W    = $clog2(CELLS + COLS);
  localparam int unsigned WIN_N  = 2 * COLS + 1;
  localparam logic [J_W-1:0] LAST_J = J_W'(CELLS + COLS - 1);

  // Configuration registers.
  logic [HEAT_W-1:0]  peak_q, hold_q;
  logic [SHIFT_W-1:0] diff_q, decay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= PEAK_RST;
      hold_q  <= HOLD_RST;
      diff_q  <= DIFF_RST;
      decay_q <= DECAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PEAK:  peak_q  <= cfg_wdata_i;
        REG_HOLD:  hold_q  <= cfg_wdata_i;
        REG_DIFF:  diff_q  <= cfg_wdata_i[SHIFT_W-1:0];
        REG_DECAY: decay_q <= cfg_wdata_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and the global pipeline advance. The whole tick pipeline
  // moves only when the output register can take or drop its word.
  state_e         state_q, state_d;
  logic           adv;
  logic           in_acc;
  logic           tick_start;
  logic           tick_done;
  logic           key_hit;
  logic [J_W-1:0] j_q;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_start = in_acc && (in_data_i.req_type == REQ_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (tick_start) state_d = ST_RUN;
      ST_RUN:   if (adv && (j_q == LAST_J)) state_d = ST_DRAIN;
      ST_DRAIN: if (tick_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // The grid lives in two banks; a tick reads the live bank and writes the
  // other one, then swaps them. Valid bits only matter until the first tick,
  // which writes every cell of the new bank.
  logic                 bank_q;
  logic [CELLS-1:0]     valid_q;
  logic [HEAT_W-1:0]    mem [DEPTH];
  logic [HEAT_W-1:0]    rdata_q;
  logic                 mem_we;
  logic [IDX_W:0]       mem_waddr;
  logic [HEAT_W-1:0]    mem_wdata;
  logic [IDX_W:0]       mem_raddr;
  logic [6:0]           key_lin;
  logic [IDX_W-1:0]     key_idx;

  assign key_lin = 7'(in_data_i.key_row) * 7'(COLS) + 7'(in_data_i.key_col);
  assign key_idx = key_lin[IDX_W-1:0];
  assign key_hit = in_acc && (in_data_i.req_type == REQ_KEY) && in_data_i.key_down
                   && ({1'b0, in_data_i.key_row} < 4'(ROWS))
                   && ({1'b0, in_data_i.key_col} < 4'(COLS));

  // Issue stage: one read per unstalled cycle, the cells then a row of lead-out.
  logic           r_v_q, r_ctr_q, r_ok_q;
  logic           rd_real;

  assign rd_real   = (j_q < J_W'(CELLS));
  assign mem_raddr = {bank_q, j_q[IDX_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q     <= '0;
      r_v_q   <= 1'b0;
      r_ctr_q <= 1'b0;
      r_ok_q  <= 1'b0;
    end else if (tick_start) begin
      j_q   <= '0;
      r_v_q <= 1'b0;
    end else if (adv) begin
      r_v_q   <= (state_q == ST_RUN);
      r_ctr_q <= (j_q >= J_W'(COLS));
      r_ok_q  <= rd_real && valid_q[j_q[IDX_W-1:0]];
      if (state_q == ST_RUN) begin
        j_q <= j_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (adv) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Shift line of two rows plus one cell. The newest cell sits at tap 0 and
  // the center at tap COLS, so its four neighbors are at fixed taps.
  logic [HEAT_W-1:0] win_q [WIN_N];
  logic              w_v_q;

  always_ff @(posedge clk_i) begin
    if (adv && r_v_q) begin
      win_q[0] <= r_ok_q ? rdata_q : '0;
      for (int i = 1; i < WIN_N; i++) begin
        win_q[i] <= win_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_v_q <= 1'b0;
    end else if (tick_start) begin
      w_v_q <= 1'b0;
    end else if (adv) begin
      w_v_q <= r_v_q && r_ctr_q;
    end
  end

  // Position of the center cell.
  logic [POS_W-1:0] crow_q, ccol_q;
  logic [IDX_W-1:0] cidx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crow_q <= '0;
      ccol_q <= '0;
      cidx_q <= '0;
    end else if (tick_start) begin
      crow_q <= '0;
      ccol_q <= '0;
      cidx_q <= '0;
    end else if (adv && w_v_q) begin
      cidx_q <= cidx_q + 1'b1;
      if (ccol_q == POS_W'(COLS - 1)) begin
        ccol_q <= '0;
        crow_q <= crow_q + 1'b1;
      end else begin
        ccol_q <= ccol_q + 1'b1;
      end
    end
  end

  // Stage 1: Laplacian of the center from its existing neighbors.
  logic                      has_up, has_dn, has_lf, has_rt;
  logic [HEAT_W+1:0]         nb_sum;
  logic [2:0]                nb_cnt;
  logic [HEAT_W+2:0]         nb_prod;
  logic signed [ARITH_W-1:0] lap_d;

  assign has_up = (crow_q != '0);
  assign has_dn = (crow_q != POS_W'(ROWS - 1));
  assign has_lf = (ccol_q != '0);
  assign has_rt = (ccol_q != POS_W'(COLS - 1));

  always_comb begin
    nb_sum = (has_up ? (HEAT_W+2)'(win_q[2*COLS]) : '0)
           + (has_dn ? (HEAT_W+2)'(win_q[0])      : '0)
           + (has_lf ? (HEAT_W+2)'(win_q[COLS+1]) : '0)
           + (has_rt ? (HEAT_W+2)'(win_q[COLS-1]) : '0);
    nb_cnt = 3'(has_up) + 3'(has_dn) + 3'(has_lf) + 3'(has_rt);
    nb_prod = (HEAT_W+3)'(nb_cnt) * (HEAT_W+3)'(win_q[COLS]);
    lap_d = $signed(ARITH_W'(nb_sum)) - $signed(ARITH_W'(nb_prod));
  end

  logic                      s1_v_q, s2_v_q, s3_v_q;
  logic signed [ARITH_W-1:0] s1_lap_q, s2_v1_q, s3_v2_q;
  logic [HEAT_W-1:0]         s1_cur_q, s2_cur_q, s3_cur_q;
  logic [POS_W-1:0]          s1_row_q, s2_row_q, s3_row_q;
  logic [POS_W-1:0]          s1_col_q, s2_col_q, s3_col_q;
  logic [IDX_W-1:0]          s1_idx_q, s2_idx_q, s3_idx_q;
  logic                      s1_last_q, s2_last_q, s3_last_q;
  logic signed [ARITH_W-1:0] cur2_s;

  assign cur2_s = $signed(ARITH_W'(s1_cur_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= w_v_q;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // Stage 2 adds the shifted Laplacian, stage 3 takes off the decay.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_lap_q  <= lap_d;
      s1_cur_q  <= win_q[COLS];
      s1_row_q  <= crow_q;
      s1_col_q  <= ccol_q;
      s1_idx_q  <= cidx_q;
      s1_last_q <= !has_dn && !has_rt;

      s2_v1_q   <= cur2_s + (s1_lap_q >>> diff_q);
      s2_cur_q  <= s1_cur_q;
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_idx_q  <= s1_idx_q;
      s2_last_q <= s1_last_q;

      s3_v2_q   <= s2_v1_q - (s2_v1_q >>> decay_q);
      s3_cur_q  <= s2_cur_q;
      s3_row_q  <= s2_row_q;
      s3_col_q  <= s2_col_q;
      s3_idx_q  <= s2_idx_q;
      s3_last_q <= s2_last_q;
    end
  end

  // Hold blend and clamp in front of the output register. The blend divides
  // by four rounding toward zero, so negative sums get a bias of three.
  logic signed [ARITH_W-1:0] cur3_s, blend_sum, blend_q4, final_v;
  logic [HEAT_W-1:0]         new_heat;

  always_comb begin
    cur3_s    = $signed(ARITH_W'(s3_cur_q));
    blend_sum = s3_v2_q + cur3_s + (cur3_s <<< 1);
    blend_q4  = blend_sum[ARITH_W-1] ? ((blend_sum + ARITH_W'(3)) >>> 2)
                                     : (blend_sum >>> 2);
    final_v   = (s3_cur_q > hold_q) ? blend_q4 : s3_v2_q;
    if (final_v[ARITH_W-1]) begin
      new_heat = '0;
    end else if (final_v > $signed(ARITH_W'(peak_q))) begin
      new_heat = peak_q;
    end else begin
      new_heat = final_v[HEAT_W-1:0];
    end
  end

  assign tick_done = adv && s3_v_q && s3_last_q;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_v_q) begin
      out_data_o.cell_row  <= s3_row_q;
      out_data_o.cell_col  <= s3_col_q;
      out_data_o.intensity <= new_heat;
      out_data_o.last_cell <= s3_last_q;
    end
  end

  // Single write port: key presses in idle, new cell values during a tick.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {bank_q, key_idx};
    mem_wdata = peak_q;
    if (adv && s3_v_q) begin
      mem_we    = 1'b1;
      mem_waddr = {!bank_q, s3_idx_q};
      mem_wdata = new_heat;
    end else if (key_hit) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q  <= 1'b0;
      valid_q <= '0;
    end else if (tick_done) begin
      bank_q  <= !bank_q;
      valid_q <= '1;
    end else if (key_hit) begin
      valid_q[key_idx] <= 1'b1;
    end
  end

endmodule
